/* rtl/core/stt_pkg.sv */
// Package with shared types and codes for the software timer table.
package stt_pkg;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_RESTART = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_QUERY   = 3'd5,
    OP_TICK    = 3'd6,
    OP_STOPALL = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_EXPIRY = 2'd2
  } kind_t;

  localparam logic [7:0] INVALID_HANDLE = 8'hFF;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  handle;
    logic [31:0] timeout;
    logic [31:0] now_time;
  } cmd_t;

  typedef struct packed {
    kind_t      result_kind;
    logic [7:0] out_handle;
    logic       active;
    logic       last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

/* rtl/core/stt_if.sv */
// Valid/ready channel interfaces for commands and results.
interface stt_cmd_if;
  import stt_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [7:0]  handle;
  logic [31:0] timeout;
  logic [31:0] now_time;
  modport source (output valid, opcode, handle, timeout, now_time, input ready);
  modport sink   (input valid, opcode, handle, timeout, now_time, output ready);
endinterface

interface stt_res_if;
  import stt_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] out_handle;
  logic       active;
  logic       last;
  modport source (output valid, result_kind, out_handle, active, last, input ready);
  modport sink   (input valid, result_kind, out_handle, active, last, output ready);
endinterface

/* rtl/core/stt_front.sv */
// Front end: accept commands and queue them for the engine.
module stt_front #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  stt_cmd_if.sink       cmd,
  output stt_pkg::cmd_t q_data,
  output logic          q_valid,
  input  logic          q_pop
);
  import stt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;

  assign cmd.ready = (count != (AW+1)'(DEPTH)) ? 1'b1 : 1'b0;
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != '0);
  assign q_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{opcode_t'(cmd.opcode), cmd.handle, cmd.timeout, cmd.now_time};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (q_pop && q_valid) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(push) - (AW+1)'(q_pop && q_valid);
    end
  end
endmodule

/* rtl/core/stt_engine.sv */
// Back end: timer table, command sequencer and result register.
module stt_engine #(
  parameter int MAX_TIMERS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  stt_pkg::cmd_t q_data,
  input  logic          q_valid,
  output logic          q_pop,
  stt_res_if.source     res
);
  import stt_pkg::*;

  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);

  // table in flip-flops: on remove, each entry above the removed one shifts down to its neighbor
  logic [7:0]  e_handle  [MAX_TIMERS];
  logic        e_started [MAX_TIMERS];
  logic [31:0] e_timeout [MAX_TIMERS];
  logic [31:0] e_start   [MAX_TIMERS];
  logic [31:0] e_elapsed [MAX_TIMERS];
  logic [CW-1:0] entry_count;
  logic [7:0]    next_handle;

  state_t state, state_next;
  cmd_t   cur;
  logic [CW-1:0] idx;
  logic          found;
  logic [IW-1:0] hit;
  logic          pend_valid;
  res_t          pend;      // expiry held until its successor is known
  res_t          out_r;
  logic          out_valid;

  logic [IW-1:0] ix;
  logic          in_range;
  logic [7:0]    srch_h;
  logic          emit_ok;

  assign ix       = idx[IW-1:0];
  assign in_range = (idx < entry_count);
  assign srch_h   = (cur.opcode == OP_CREATE) ? next_handle : cur.handle;
  assign emit_ok  = !out_valid || res.ready;

  assign res.valid       = out_valid;
  assign res.result_kind = out_r.result_kind;
  assign res.out_handle  = out_r.out_handle;
  assign res.active      = out_r.active;
  assign res.last        = out_r.last;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (q_valid) begin
        state_next = (q_data.opcode == OP_TICK) ? ST_SCAN :
                     (q_data.opcode == OP_STOPALL) ? ST_IDLE : ST_SEARCH;
      end
      ST_SEARCH: if (!in_range || (srch_h != INVALID_HANDLE && e_handle[ix] == srch_h)) begin
        state_next = ST_EMIT;
      end
      ST_SCAN:   if (!in_range) state_next = ST_EMIT;
      ST_EMIT:   if (emit_ok) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign q_pop = (state == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      next_handle <= '0;
      out_valid   <= 1'b0;
      pend_valid  <= 1'b0;
      for (int i = 0; i < MAX_TIMERS; i++) e_started[i] <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && res.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (q_valid) begin
          cur        <= q_data;
          idx        <= '0;
          found      <= 1'b0;
          pend_valid <= 1'b0;
          if (q_data.opcode == OP_STOPALL) begin
            for (int i = 0; i < MAX_TIMERS; i++) e_started[i] <= 1'b0;
          end
        end
        ST_SEARCH: begin
          // stop at the first free slot so a create appends there
          if (in_range && srch_h != INVALID_HANDLE && e_handle[ix] == srch_h) begin
            found <= 1'b1;
            hit   <= ix;
          end else if (in_range) begin
            idx <= idx + CW'(1);
          end
        end
        ST_SCAN: if (in_range) begin
          // on an expired entry, advance only when the pending expiry can be pushed out
          if (e_started[ix] && e_elapsed[ix] > e_timeout[ix]) begin
            if (!pend_valid || emit_ok) begin
              e_started[ix] <= 1'b0;
              if (pend_valid) begin
                out_r     <= pend;
                out_valid <= 1'b1;
              end
              pend       <= '{KIND_EXPIRY, e_handle[ix], 1'b0, 1'b0};
              pend_valid <= 1'b1;
              idx        <= idx + CW'(1);
            end
          end else begin
            if (e_started[ix]) e_elapsed[ix] <= cur.now_time - e_start[ix];
            idx <= idx + CW'(1);
          end
        end
        ST_EMIT: if (emit_ok) begin
          case (cur.opcode)
            OP_CREATE: begin
              out_valid <= 1'b1;
              if (next_handle != INVALID_HANDLE && entry_count < CW'(MAX_TIMERS) &&
                  !found) begin
                e_handle[ix]  <= next_handle;
                e_started[ix] <= 1'b0;
                e_timeout[ix] <= cur.timeout;
                e_start[ix]   <= '0;
                e_elapsed[ix] <= '0;
                entry_count   <= entry_count + CW'(1);
                next_handle   <= next_handle + 8'd1;
                out_r <= '{KIND_CREATE, next_handle, 1'b0, 1'b1};
              end else begin
                out_r <= '{KIND_CREATE, INVALID_HANDLE, 1'b0, 1'b1};
              end
            end
            OP_QUERY: begin
              out_valid <= 1'b1;
              out_r <= '{KIND_QUERY, cur.handle, found && e_started[hit], 1'b1};
            end
            OP_START, OP_RESTART: if (found &&
                (!e_started[hit] || cur.opcode == OP_RESTART)) begin
              e_started[hit] <= 1'b1;
              e_start[hit]   <= cur.now_time;
              e_elapsed[hit] <= '0;
            end
            OP_STOP: if (found) e_started[hit] <= 1'b0;
            OP_REMOVE: if (found) begin
              for (int i = 0; i < MAX_TIMERS - 1; i++) begin
                if (IW'(i) >= hit) begin
                  e_handle[i]  <= e_handle[i+1];
                  e_started[i] <= e_started[i+1];
                  e_timeout[i] <= e_timeout[i+1];
                  e_start[i]   <= e_start[i+1];
                  e_elapsed[i] <= e_elapsed[i+1];
                end
              end
              e_started[MAX_TIMERS-1] <= 1'b0;
              entry_count <= entry_count - CW'(1);
            end
            OP_TICK: if (pend_valid) begin
              out_r      <= '{pend.result_kind, pend.out_handle, 1'b0, 1'b1};
              out_valid  <= 1'b1;
              pend_valid <= 1'b0;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end
endmodule

/* rtl/core/software_timer_table.sv */
// Top level of the software timer table.
// A create/query passes the front queue, IDLE, SEARCH up to the match or entry_count,
// then EMIT; a tick scans all entry_count entries in SCAN before EMIT, plus stalls.
// Throughput: one command at a time in the engine; a two-entry queue lets the
// front accept while the engine works. SCAN moves one entry per cycle unless res stalls.
// Reset (rst, synchronous): table empty, all timers stopped, handle counter zero.
module software_timer_table #(
  parameter int MAX_TIMERS = 16
) (
  input logic       clk,
  input logic       rst,
  stt_cmd_if.sink   cmd,
  stt_res_if.source res
);
  import stt_pkg::*;

  cmd_t q_data;
  logic q_valid;
  logic q_pop;

  // front: hold accepted transactions until the engine is free
  stt_front #(.DEPTH(2)) u_front (
    .clk, .rst, .cmd, .q_data, .q_valid, .q_pop
  );

  // back: search, update or scan the table and drive results
  stt_engine #(.MAX_TIMERS(MAX_TIMERS)) u_engine (
    .clk, .rst, .q_data, .q_valid, .q_pop, .res
  );
endmodule

/* rtl/core/stt_checker.sv */
// Port-level checker for the software timer table, bound to the top level.
module stt_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_kind,
  input logic       res_active,
  input logic [7:0] res_handle
);
  import stt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_handle)) else $error("result dropped");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_kind == KIND_CREATE || res_kind == KIND_QUERY ||
                   res_kind == KIND_EXPIRY)) else $error("bad kind");
  a_act: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind != KIND_QUERY |-> !res_active) else $error("active on non-query");
  a_exp: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_EXPIRY |-> res_handle != INVALID_HANDLE)
    else $error("expiry of invalid");
endmodule

bind software_timer_table stt_checker u_chk (
  .clk(clk), .rst(rst), .res_valid(res.valid), .res_ready(res.ready),
  .res_kind(res.result_kind), .res_active(res.active), .res_handle(res.out_handle)
);
